// ===== rtl/key_press_event_detector_defines.svh =====
// Assertion macros shared by the key press event detector RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef KEY_PRESS_EVENT_DETECTOR_DEFINES_SVH
`define KEY_PRESS_EVENT_DETECTOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KPED_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key press event detector check failed");

// next-cycle implication, checked outside reset
`define KPED_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key press event detector check failed");

`endif

// ===== rtl/kped_pkg.sv =====
// Shared constants, codes and types of the key press event detector.
// Depends on nothing; used by every module of the block.
package kped_pkg;

   localparam int KEY_COUNT = 4;
   localparam int EV_W      = 3;
   localparam int CNT_W     = 16;
   localparam int MASK_W    = KEY_COUNT;
   localparam int OUT_W     = KEY_COUNT * EV_W;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_CONFIRM = 3'd1;
   localparam logic [2:0] PH_PRESSED = 3'd2;
   localparam logic [2:0] PH_WAITING = 3'd3;
   localparam logic [2:0] PH_LONG    = 3'd4;
   localparam logic [2:0] PH_DOUBLE  = 3'd5;

   localparam logic [EV_W-1:0] EV_NONE         = 3'd0;
   localparam logic [EV_W-1:0] EV_PRESS        = 3'd1;
   localparam logic [EV_W-1:0] EV_RELEASE      = 3'd2;
   localparam logic [EV_W-1:0] EV_LONG_PRESS   = 3'd3;
   localparam logic [EV_W-1:0] EV_LONG_RELEASE = 3'd4;
   localparam logic [EV_W-1:0] EV_DOUBLE_PRESS = 3'd5;

   localparam logic [1:0] REG_LONG_TICKS   = 2'd0;
   localparam logic [1:0] REG_WINDOW_TICKS = 2'd1;
   localparam logic [1:0] REG_ACTIVE_LEVEL = 2'd2;
   localparam logic [1:0] REG_LOCK         = 2'd3;

   localparam logic [CNT_W-1:0]  RST_LONG_TICKS   = 16'd100;
   localparam logic [CNT_W-1:0]  RST_WINDOW_TICKS = 16'd30;
   localparam logic [MASK_W-1:0] RST_ACTIVE_LEVEL = {MASK_W{1'b1}};
   localparam logic [MASK_W-1:0] RST_LOCK         = {MASK_W{1'b0}};

   typedef struct packed {
      logic [CNT_W-1:0] long_ticks;
      logic [CNT_W-1:0] window_ticks;
   } cfg_type;

   typedef logic [KEY_COUNT-1:0][EV_W-1:0] lane_events_type;

endpackage

// ===== rtl/key_press_event_detector.sv =====
// Key press event detector: four key lanes, a merging output stage and
// the register file. Depends on kped_pkg, kped_lane and kped_merge.
//
// One scan tick is taken per clock cycle while req_stall is low. Each key has its own lane that
// decides that key's event in the cycle the tick is taken; the packed result
// is registered in an output register and appears on rsp_ from it. A skid register
// behind it lets two beats back up before req_stall rises, so a stalled
// result never blocks the tick that follows it. Locked keys keep their state
// and report none. Registers are written through the csr_ port at byte
// addresses 0, 4, 8 and 12 and should be written only while no tick is in flight.
module key_press_event_detector (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [kped_pkg::KEY_COUNT-1:0]     req_pin_levels,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [kped_pkg::OUT_W-1:0]         rsp_key_events,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [kped_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [kped_pkg::DATA_W-1:0]        csr_pwdata,
   output logic [kped_pkg::DATA_W-1:0]        csr_prdata,
   output logic                               csr_pready
);

   logic [kped_pkg::CNT_W-1:0]   long_ticks_ff, long_ticks_in;
   logic [kped_pkg::CNT_W-1:0]   window_ticks_ff, window_ticks_in;
   logic [kped_pkg::MASK_W-1:0]  active_level_ff, active_level_in;
   logic [kped_pkg::MASK_W-1:0]  lock_ff, lock_in;
   logic                         csr_write;
   logic [1:0]                   reg_sel;
   logic                         req_beat;
   logic                         merge_full;
   kped_pkg::cfg_type            cfg;
   kped_pkg::lane_events_type    lane_events;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[3:2];

   always_comb begin
      long_ticks_in   = long_ticks_ff;
      window_ticks_in = window_ticks_ff;
      active_level_in = active_level_ff;
      lock_in         = lock_ff;
      if (csr_write) begin
         unique case (reg_sel)
            kped_pkg::REG_LONG_TICKS:   long_ticks_in   = csr_pwdata[kped_pkg::CNT_W-1:0];
            kped_pkg::REG_WINDOW_TICKS: window_ticks_in = csr_pwdata[kped_pkg::CNT_W-1:0];
            kped_pkg::REG_ACTIVE_LEVEL: active_level_in = csr_pwdata[kped_pkg::MASK_W-1:0];
            kped_pkg::REG_LOCK:         lock_in         = csr_pwdata[kped_pkg::MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         kped_pkg::REG_LONG_TICKS:   csr_prdata = kped_pkg::DATA_W'(long_ticks_ff);
         kped_pkg::REG_WINDOW_TICKS: csr_prdata = kped_pkg::DATA_W'(window_ticks_ff);
         kped_pkg::REG_ACTIVE_LEVEL: csr_prdata = kped_pkg::DATA_W'(active_level_ff);
         kped_pkg::REG_LOCK:         csr_prdata = kped_pkg::DATA_W'(lock_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ticks_ff   <= kped_pkg::RST_LONG_TICKS;
         window_ticks_ff <= kped_pkg::RST_WINDOW_TICKS;
         active_level_ff <= kped_pkg::RST_ACTIVE_LEVEL;
         lock_ff         <= kped_pkg::RST_LOCK;
      end else begin
         long_ticks_ff   <= long_ticks_in;
         window_ticks_ff <= window_ticks_in;
         active_level_ff <= active_level_in;
         lock_ff         <= lock_in;
      end
   end

   assign cfg.long_ticks   = long_ticks_ff;
   assign cfg.window_ticks = window_ticks_ff;

   assign req_stall = merge_full;
   assign req_beat  = req_valid && !merge_full;

   for (genvar k = 0; k < kped_pkg::KEY_COUNT; k++) begin : g_lane
      kped_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .step_en    (req_beat),
         .lock       (lock_ff[k]),
         .active     (req_pin_levels[k] == active_level_ff[k]),
         .cfg        (cfg),
         .event_code (lane_events[k])
      );
   end

   kped_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_beat     (req_beat),
      .lane_events (lane_events),
      .full        (merge_full),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_events  (rsp_key_events)
   );

endmodule

// ===== rtl/kped_lane.sv =====
// One key lane: debounce, press, long press and double press state machine.
// Depends on kped_pkg and key_press_event_detector_defines.svh.
`include "key_press_event_detector_defines.svh"

module kped_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic                          lock,
   input  logic                          active,
   input  kped_pkg::cfg_type             cfg,
   output logic [kped_pkg::EV_W-1:0]     event_code
);

   logic [2:0]                  phase_ff, phase_in, phase_nx;
   logic [kped_pkg::CNT_W-1:0]  count_ff, count_in, count_nx;
   logic [kped_pkg::CNT_W-1:0]  count_inc, count_dec;
   logic [kped_pkg::EV_W-1:0]   ev;

   assign count_inc = (count_ff == {kped_pkg::CNT_W{1'b1}}) ? count_ff
                                                           : count_ff + kped_pkg::CNT_W'(1);
   assign count_dec = count_ff - kped_pkg::CNT_W'(1);

   always_comb begin
      phase_nx = phase_ff;
      count_nx = count_ff;
      ev       = kped_pkg::EV_NONE;
      unique case (phase_ff)
         kped_pkg::PH_IDLE: begin
            if (active) phase_nx = kped_pkg::PH_CONFIRM;
         end
         kped_pkg::PH_CONFIRM: begin
            if (active) begin
               phase_nx = kped_pkg::PH_PRESSED;
               count_nx = '0;
               ev       = kped_pkg::EV_PRESS;
            end else begin
               phase_nx = kped_pkg::PH_IDLE;
            end
         end
         kped_pkg::PH_PRESSED: begin
            if (!active) begin
               phase_nx = kped_pkg::PH_WAITING;
               count_nx = cfg.window_ticks;
               ev       = kped_pkg::EV_RELEASE;
            end else if (count_inc >= cfg.long_ticks) begin
               phase_nx = kped_pkg::PH_LONG;
               count_nx = '0;
               ev       = kped_pkg::EV_LONG_PRESS;
            end else begin
               count_nx = count_inc;
            end
         end
         kped_pkg::PH_WAITING: begin
            if (count_ff == '0) begin
               phase_nx = kped_pkg::PH_IDLE;
            end else if (active) begin
               phase_nx = kped_pkg::PH_DOUBLE;
               count_nx = '0;
               ev       = kped_pkg::EV_DOUBLE_PRESS;
            end else begin
               count_nx = count_dec;
               if (count_dec == '0) phase_nx = kped_pkg::PH_IDLE;
            end
         end
         kped_pkg::PH_LONG: begin
            if (!active) begin
               phase_nx = kped_pkg::PH_IDLE;
               ev       = kped_pkg::EV_LONG_RELEASE;
            end else if (count_inc >= cfg.long_ticks) begin
               count_nx = '0;
            end else begin
               count_nx = count_inc;
            end
         end
         kped_pkg::PH_DOUBLE: begin
            if (!active) phase_nx = kped_pkg::PH_IDLE;
         end
         default: begin
            phase_nx = kped_pkg::PH_IDLE;
         end
      endcase
   end

   assign phase_in   = (step_en && !lock) ? phase_nx : phase_ff;
   assign count_in   = (step_en && !lock) ? count_nx : count_ff;
   assign event_code = lock ? kped_pkg::EV_NONE : ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= kped_pkg::PH_IDLE;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   `KPED_ASSERT_NOW(a_lock_quiet, clock, reset, lock, event_code == kped_pkg::EV_NONE)
   `KPED_ASSERT_NEXT(a_press_clears, clock, reset,
                     step_en && event_code == kped_pkg::EV_PRESS,
                     phase_ff == kped_pkg::PH_PRESSED && count_ff == '0)
   `KPED_ASSERT_NEXT(a_locked_holds, clock, reset, lock,
                     phase_ff == $past(phase_ff) && count_ff == $past(count_ff))

endmodule

// ===== rtl/kped_merge.sv =====
// Merging stage: packs the lane events into one beat and holds it in an
// output register backed by a skid register. Depends on kped_pkg and the defines.
`include "key_press_event_detector_defines.svh"

module kped_merge (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_beat,
   input  kped_pkg::lane_events_type       lane_events,
   output logic                            full,
   output logic                            out_valid,
   input  logic                            out_stall,
   output logic [kped_pkg::OUT_W-1:0]      out_events
);

   logic                          out_valid_ff, out_valid_in;
   logic                          skid_valid_ff, skid_valid_in;
   logic [kped_pkg::OUT_W-1:0]    out_data_ff, out_data_in;
   logic [kped_pkg::OUT_W-1:0]    skid_data_ff, skid_data_in;
   logic [kped_pkg::OUT_W-1:0]    packed_events;
   logic                          out_free;

   assign packed_events = lane_events;
   assign out_free      = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = in_beat;
            out_data_in   = packed_events;
         end
      end else if (in_beat) begin
         skid_valid_in = 1'b1;
         skid_data_in  = packed_events;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full       = skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_events = out_data_ff;

   `KPED_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `KPED_ASSERT_NOW(a_no_beat_when_full, clock, reset, skid_valid_ff, !in_beat)
   `KPED_ASSERT_NEXT(a_stalled_beat_parks, clock, reset,
                     in_beat && out_valid_ff && out_stall,
                     skid_valid_ff && skid_data_ff == $past(packed_events))

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of key_press_event_detector: directed and random scan ticks
// checked against a per-key event predictor, with register writes and reads over csr_.
// Depends on kped_pkg and the RTL of the block only.
module testbench;

   localparam int QUIET_LIMIT = 2000;
   localparam int RUN_CAP     = 60;

   logic                           clock          = 1'b0;
   logic                           reset          = 1'b1;
   logic                           req_valid      = 1'b0;
   logic                           req_stall;
   logic [kped_pkg::KEY_COUNT-1:0] req_pin_levels = '0;
   logic                           rsp_valid;
   logic                           rsp_stall      = 1'b0;
   logic [kped_pkg::OUT_W-1:0]     rsp_key_events;
   logic                           csr_psel       = 1'b0;
   logic                           csr_penable    = 1'b0;
   logic                           csr_pwrite     = 1'b0;
   logic [kped_pkg::ADDR_W-1:0]    csr_paddr      = '0;
   logic [kped_pkg::DATA_W-1:0]    csr_pwdata     = '0;
   logic [kped_pkg::DATA_W-1:0]    csr_prdata;
   logic                           csr_pready;

   // per-key predictor state and register copies
   logic [2:0]                  key_phase [kped_pkg::KEY_COUNT];
   logic [kped_pkg::CNT_W-1:0]  key_count [kped_pkg::KEY_COUNT];
   logic [kped_pkg::CNT_W-1:0]  long_ticks;
   logic [kped_pkg::CNT_W-1:0]  window_ticks;
   logic [kped_pkg::MASK_W-1:0] active_level;
   logic [kped_pkg::MASK_W-1:0] lock_keys;

   logic [kped_pkg::OUT_W-1:0] expected_events [$];
   int error_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles  = 0;

   // random press pattern: remaining ticks of the current run per key
   int   run_left [kped_pkg::KEY_COUNT];
   logic run_held [kped_pkg::KEY_COUNT];

   key_press_event_detector u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pin_levels (req_pin_levels),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_key_events (rsp_key_events),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [kped_pkg::CNT_W-1:0] count_up(logic [kped_pkg::CNT_W-1:0] value);
      return (value == {kped_pkg::CNT_W{1'b1}}) ? value : value + kped_pkg::CNT_W'(1);
   endfunction

   function automatic logic [kped_pkg::EV_W-1:0] key_step_event(int k, logic active);
      logic [kped_pkg::EV_W-1:0] ev;
      ev = kped_pkg::EV_NONE;
      case (key_phase[k])
         kped_pkg::PH_IDLE: begin
            if (active) key_phase[k] = kped_pkg::PH_CONFIRM;
         end
         kped_pkg::PH_CONFIRM: begin
            if (active) begin
               key_phase[k] = kped_pkg::PH_PRESSED;
               key_count[k] = '0;
               ev = kped_pkg::EV_PRESS;
            end else begin
               key_phase[k] = kped_pkg::PH_IDLE;
            end
         end
         kped_pkg::PH_PRESSED: begin
            if (!active) begin
               key_phase[k] = kped_pkg::PH_WAITING;
               key_count[k] = window_ticks;
               ev = kped_pkg::EV_RELEASE;
            end else begin
               key_count[k] = count_up(key_count[k]);
               if (key_count[k] >= long_ticks) begin
                  key_phase[k] = kped_pkg::PH_LONG;
                  key_count[k] = '0;
                  ev = kped_pkg::EV_LONG_PRESS;
               end
            end
         end
         kped_pkg::PH_WAITING: begin
            if (key_count[k] == '0) begin
               key_phase[k] = kped_pkg::PH_IDLE;
            end else if (active) begin
               key_phase[k] = kped_pkg::PH_DOUBLE;
               key_count[k] = '0;
               ev = kped_pkg::EV_DOUBLE_PRESS;
            end else begin
               key_count[k] = key_count[k] - kped_pkg::CNT_W'(1);
               if (key_count[k] == '0) key_phase[k] = kped_pkg::PH_IDLE;
            end
         end
         kped_pkg::PH_LONG: begin
            if (!active) begin
               key_phase[k] = kped_pkg::PH_IDLE;
               ev = kped_pkg::EV_LONG_RELEASE;
            end else begin
               key_count[k] = count_up(key_count[k]);
               if (key_count[k] >= long_ticks) key_count[k] = '0;
            end
         end
         kped_pkg::PH_DOUBLE: begin
            if (!active) key_phase[k] = kped_pkg::PH_IDLE;
         end
         default: begin
            key_phase[k] = kped_pkg::PH_IDLE;
         end
      endcase
      return ev;
   endfunction

   function automatic logic [kped_pkg::OUT_W-1:0] scan_tick(
      logic [kped_pkg::KEY_COUNT-1:0] pins);
      logic [kped_pkg::OUT_W-1:0] events;
      events = '0;
      for (int k = 0; k < kped_pkg::KEY_COUNT; k++) begin
         if (!lock_keys[k])
            events[kped_pkg::EV_W*k +: kped_pkg::EV_W] =
               key_step_event(k, pins[k] == active_level[k]);
      end
      return events;
   endfunction

   task automatic send_tick(input logic [kped_pkg::KEY_COUNT-1:0] pins);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pin_levels <= pins;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_events.push_back(scan_tick(pins));
   endtask

   // act bit set means key pressed; pin level follows the active level of the key
   task automatic send_active(input logic [kped_pkg::KEY_COUNT-1:0] act);
      send_tick(~(act ^ active_level));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [1:0] index,
                             input logic [kped_pkg::DATA_W-1:0] wdata,
                             output logic [kped_pkg::DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      if (write) begin
         case (index)
            kped_pkg::REG_LONG_TICKS:   long_ticks   = wdata[kped_pkg::CNT_W-1:0];
            kped_pkg::REG_WINDOW_TICKS: window_ticks = wdata[kped_pkg::CNT_W-1:0];
            kped_pkg::REG_ACTIVE_LEVEL: active_level = wdata[kped_pkg::MASK_W-1:0];
            kped_pkg::REG_LOCK:         lock_keys    = wdata[kped_pkg::MASK_W-1:0];
            default: ;
         endcase
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [kped_pkg::DATA_W-1:0] value);
      logic [kped_pkg::DATA_W-1:0] unused;
      csr_access(1'b1, index, value, unused);
   endtask

   task automatic check_reg(input logic [1:0] index);
      logic [kped_pkg::DATA_W-1:0] rdata;
      logic [kped_pkg::DATA_W-1:0] want;
      logic [kped_pkg::DATA_W-1:0] mask;
      want = '0;
      mask = kped_pkg::DATA_W'({kped_pkg::MASK_W{1'b1}});
      csr_access(1'b0, index, '0, rdata);
      case (index)
         kped_pkg::REG_LONG_TICKS: begin
            want = kped_pkg::DATA_W'(long_ticks);
            mask = kped_pkg::DATA_W'({kped_pkg::CNT_W{1'b1}});
         end
         kped_pkg::REG_WINDOW_TICKS: begin
            want = kped_pkg::DATA_W'(window_ticks);
            mask = kped_pkg::DATA_W'({kped_pkg::CNT_W{1'b1}});
         end
         kped_pkg::REG_ACTIVE_LEVEL: want = kped_pkg::DATA_W'(active_level);
         kped_pkg::REG_LOCK:         want = kped_pkg::DATA_W'(lock_keys);
         default: ;
      endcase
      if ((rdata & mask) !== want) begin
         error_count++;
         $error("csr_prdata (register %0d): expected %0h, actual %0h", index, want,
                rdata & mask);
      end
   endtask

   task automatic configure(input logic [kped_pkg::CNT_W-1:0] long_cfg,
                            input logic [kped_pkg::CNT_W-1:0] window_cfg,
                            input logic [kped_pkg::MASK_W-1:0] level_cfg,
                            input logic [kped_pkg::MASK_W-1:0] lock_cfg);
      drain();
      write_reg(kped_pkg::REG_LONG_TICKS, kped_pkg::DATA_W'(long_cfg));
      write_reg(kped_pkg::REG_WINDOW_TICKS, kped_pkg::DATA_W'(window_cfg));
      write_reg(kped_pkg::REG_ACTIVE_LEVEL, kped_pkg::DATA_W'(level_cfg));
      write_reg(kped_pkg::REG_LOCK, kped_pkg::DATA_W'(lock_cfg));
   endtask

   function automatic int run_length(logic held);
      int span;
      int len;
      span = held ? int'(long_ticks) : int'(window_ticks);
      if (span > RUN_CAP) span = RUN_CAP;
      case ($urandom_range(3))
         0:       len = int'($urandom_range(2, 1));
         3:       len = int'($urandom_range(span + span / 2 + 3, span));
         default: len = int'($urandom_range(span + 2, 1));
      endcase
      return (len < 1) ? 1 : len;
   endfunction

   function automatic logic [kped_pkg::KEY_COUNT-1:0] next_activity();
      logic [kped_pkg::KEY_COUNT-1:0] act;
      for (int k = 0; k < kped_pkg::KEY_COUNT; k++) begin
         if (run_left[k] == 0) begin
            run_held[k] = !run_held[k];
            run_left[k] = run_length(run_held[k]);
         end
         run_left[k]--;
         act[k] = run_held[k];
      end
      return act;
   endfunction

   task automatic test_register_access();
      logic [1:0] regs [4];
      regs = '{kped_pkg::REG_LONG_TICKS, kped_pkg::REG_WINDOW_TICKS,
               kped_pkg::REG_ACTIVE_LEVEL, kped_pkg::REG_LOCK};
      foreach (regs[i]) check_reg(regs[i]);
      foreach (regs[i]) begin
         write_reg(regs[i], '0);
         check_reg(regs[i]);
         write_reg(regs[i], '1);
         check_reg(regs[i]);
         write_reg(regs[i], $urandom());
         check_reg(regs[i]);
      end
   endtask

   // press/double, long press, bounce in confirm and window expiry side by side
   task automatic test_event_sequences();
      configure(16'd3, 16'd2, 4'b1010, 4'b0000);
      send_active(4'b0111);
      send_active(4'b1111);
      send_active(4'b0010);
      send_active(4'b0011);
      send_active(4'b0011);
      send_active(4'b0010);
      send_active(4'b0000);
      send_active(4'b1111);
      send_active(4'b0000);
      send_active(4'b0000);
   endtask

   task automatic test_zero_thresholds();
      configure(16'd0, 16'd0, 4'b0000, 4'b0000);
      send_active(4'b1111);
      send_active(4'b1111);
      send_active(4'b1111);
      send_active(4'b0000);
      send_active(4'b1111);
      send_active(4'b1111);
      send_active(4'b0000);
      send_active(4'b1111);
      send_active(4'b0000);
   endtask

   task automatic test_locked_keys();
      configure(16'd2, 16'd3, 4'b1111, 4'b0101);
      send_active(4'b1111);
      send_active(4'b1111);
      send_active(4'b1111);
      drain();
      write_reg(kped_pkg::REG_LOCK, kped_pkg::DATA_W'(4'b1010));
      send_active(4'b1111);
      send_active(4'b0000);
      drain();
      write_reg(kped_pkg::REG_LOCK, kped_pkg::DATA_W'(4'b0000));
      send_active(4'b0000);
      send_active(4'b1111);
   endtask

   task automatic test_random_traffic(input int items,
                                      input logic [kped_pkg::CNT_W-1:0] long_cfg,
                                      input logic [kped_pkg::CNT_W-1:0] window_cfg,
                                      input logic [kped_pkg::MASK_W-1:0] level_cfg,
                                      input logic [kped_pkg::MASK_W-1:0] lock_cfg);
      configure(long_cfg, window_cfg, level_cfg, lock_cfg);
      for (int k = 0; k < kped_pkg::KEY_COUNT; k++) begin
         run_left[k] = 0;
         run_held[k] = 1'b0;
      end
      repeat (items) begin
         if ($urandom_range(9) == 0) send_tick(kped_pkg::KEY_COUNT'($urandom_range(15)));
         else send_active(next_activity());
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            error_count++;
            $error("key_events: expected none, actual %03h", rsp_key_events);
         end else begin
            if (rsp_key_events !== expected_events[0]) begin
               error_count++;
               $error("key_events: expected %03h, actual %03h", expected_events[0],
                      rsp_key_events);
            end
            void'(expected_events.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < kped_pkg::KEY_COUNT; k++) begin
         key_phase[k] = kped_pkg::PH_IDLE;
         key_count[k] = '0;
      end
      long_ticks    = kped_pkg::RST_LONG_TICKS;
      window_ticks  = kped_pkg::RST_WINDOW_TICKS;
      active_level  = kped_pkg::RST_ACTIVE_LEVEL;
      lock_keys     = kped_pkg::RST_LOCK;
      send_idle_pct = 35;
      recv_idle_pct = 76;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_event_sequences();
      test_zero_thresholds();
      test_locked_keys();
      test_random_traffic(270, kped_pkg::CNT_W'($urandom_range(12, 2)),
                          kped_pkg::CNT_W'($urandom_range(10, 1)),
                          kped_pkg::MASK_W'($urandom_range(15)), 4'b0000);
      test_random_traffic(270, kped_pkg::CNT_W'($urandom_range(30, 1)),
                          kped_pkg::CNT_W'($urandom_range(30, 1)),
                          kped_pkg::MASK_W'($urandom_range(15)),
                          kped_pkg::MASK_W'($urandom_range(15)));

      drain();
      send_idle_pct = 76;
      recv_idle_pct = 35;
      test_random_traffic(270, 16'd1, 16'hFFFF, 4'b0000, 4'b0000);
      test_random_traffic(270, 16'hFFFF, 16'd1, 4'b1111,
                          kped_pkg::MASK_W'($urandom_range(15)));

      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(270, kped_pkg::CNT_W'($urandom_range(20, 2)),
                          kped_pkg::CNT_W'($urandom_range(20, 2)),
                          kped_pkg::MASK_W'($urandom_range(15)), 4'b0000);
      test_random_traffic(270, kped_pkg::CNT_W'($urandom_range(40, 3)),
                          kped_pkg::CNT_W'($urandom_range(5, 1)),
                          kped_pkg::MASK_W'($urandom_range(15)),
                          kped_pkg::MASK_W'($urandom_range(15)));

      drain();
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_events.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
